// File: src/pci_class_match_scanner_defines.svh
// Assertion macros for the class match scanner.
// Used by the RTL files that carry concurrent checks; no other dependencies.
`ifndef PCI_CLASS_MATCH_SCANNER_DEFINES_SVH
`define PCI_CLASS_MATCH_SCANNER_DEFINES_SVH

`ifndef SYNTH
// Check a property on every rising clock edge outside reset.
`define PCMS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition in one cycle implies a result in the next.
`define PCMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PCMS_ASSERT(label, clk, rst_n, prop, msg)
`define PCMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: src/pcms_pkg.sv
// Shared types, codes and constants for the class match scanner.
// Used by pci_class_match_scanner; has no dependencies of its own.
package pcms_pkg;

	// Bus geometry
	localparam logic [5:0] DEVICES_PER_BUS      = 6'd32;
	localparam logic [3:0] FUNCTIONS_PER_DEVICE = 4'd8;

	// Config space register offsets
	localparam logic [7:0] OFF_ID    = 8'h00;
	localparam logic [7:0] OFF_CMD   = 8'h04;
	localparam logic [7:0] OFF_CLASS = 8'h08;
	localparam logic [7:0] OFF_BAR0  = 8'h10;

	localparam logic [15:0] VENDOR_ABSENT = 16'hFFFF;
	localparam logic [31:0] CMD_SET_BITS  = 32'h0000_0002 | 32'h0000_0004;
	localparam logic [31:0] BAR_ADDR_MASK = 32'hFFFF_FFF0;

	// Input op codes
	localparam logic OP_START    = 1'b0;
	localparam logic OP_RESPONSE = 1'b1;

	// Result kinds
	localparam logic [1:0] KIND_READ      = 2'd0;
	localparam logic [1:0] KIND_WRITE     = 2'd1;
	localparam logic [1:0] KIND_FOUND     = 2'd2;
	localparam logic [1:0] KIND_NOT_FOUND = 2'd3;

	// Register file
	localparam int unsigned APB_AW = 4;
	localparam logic [1:0] REG_MATCH_CLASS = 2'd0;
	localparam logic [1:0] REG_WINDOW_BASE = 2'd1;
	localparam logic [1:0] REG_WINDOW_SIZE = 2'd2;
	localparam logic [23:0] MATCH_CLASS_RESET = 24'h0C0330;

	// Result queue
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [5:0] {
		PH_IDLE  = 6'b000001,
		PH_ID    = 6'b000010,
		PH_CLASS = 6'b000100,
		PH_BAR   = 6'b001000,
		PH_CMD   = 6'b010000,
		PH_DONE  = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [4:0]  dev;
		logic [2:0]  fn;
		logic [7:0]  off;
		logic [31:0] wdata;
		logic [31:0] bar;
		logic        last;
	} result_t;

	function automatic result_t mk_result(logic [1:0] kind, logic [4:0] dev, logic [2:0] fn,
			logic [7:0] off, logic [31:0] wdata, logic [31:0] bar, logic last);
		result_t r;
		r.kind  = kind;
		r.dev   = dev;
		r.fn    = fn;
		r.off   = off;
		r.wdata = wdata;
		r.bar   = bar;
		r.last  = last;
		return r;
	endfunction

endpackage

// File: src/pci_class_match_scanner.sv
// Scanner of bus 0 in an ECAM config space: issues config reads, matches class and BAR0.
// Depends on pcms_pkg and pci_class_match_scanner_defines.svh.
//
// Every accepted item (a start or a config read response) is decoded in the cycle it is
// accepted and its zero, one or two result items are written into a four-entry result
// queue, so one input item can be taken every clock while the queue has room for two.
// Results leave the queue one per cycle while out_ready is high; the matching response
// that yields the command write and the found report puts both out in turn. in_ready is
// high whenever the queue has room for two results and ignores out_ready. Responses that
// arrive before a start or after the scan ends yield nothing. There is no clearing pass.
`include "pci_class_match_scanner_defines.svh"

module pci_class_match_scanner (
	input  logic                        clk,
	input  logic                        arst_n,
	// config port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pcms_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	// input channel
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        op,
	input  logic [31:0]                 read_data,
	// result channel
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  kind,
	output logic [4:0]                  device_number,
	output logic [2:0]                  function_number,
	output logic [7:0]                  reg_offset,
	output logic [19:0]                 ecam_offset,
	output logic [31:0]                 write_data,
	output logic [31:0]                 bar_address,
	output logic                        last
);

	// Configuration registers
	logic [23:0] match_class_q;
	logic [31:0] window_base_q;
	logic [31:0] window_size_q;
	logic        cfg_wr;
	logic [1:0]  cfg_idx;

	// Scan state
	pcms_pkg::phase_t phase_q, phase_n;
	logic [4:0]  dev_q, dev_n;
	logic [2:0]  fn_q, fn_n;
	logic [31:0] bar_q, bar_n;

	// Result queue
	pcms_pkg::result_t           q_mem [pcms_pkg::QDEPTH];
	logic [pcms_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [pcms_pkg::QCNT_W-1:0] cnt_q;
	logic [1:0]                  push_n;
	logic                        pop;
	logic                        accept;
	pcms_pkg::result_t           res0, res1, head;

	// Decode helpers
	logic        adv, whole_dev, rd_req;
	logic [7:0]  rd_off;
	logic [3:0]  fn_inc;
	logic [5:0]  dev_inc;
	logic [31:0] bar_val;
	logic [32:0] win_top;
	logic        bar_ok;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[pcms_pkg::APB_AW-1:2];
	assign cfg_wr  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_class_q <= pcms_pkg::MATCH_CLASS_RESET;
			window_base_q <= '0;
			window_size_q <= '0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				pcms_pkg::REG_MATCH_CLASS: match_class_q <= pwdata[23:0];
				pcms_pkg::REG_WINDOW_BASE: window_base_q <= pwdata;
				pcms_pkg::REG_WINDOW_SIZE: window_size_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			pcms_pkg::REG_MATCH_CLASS: prdata = {8'h00, match_class_q};
			pcms_pkg::REG_WINDOW_BASE: prdata = window_base_q;
			pcms_pkg::REG_WINDOW_SIZE: prdata = window_size_q;
			default:                   prdata = '0;
		endcase
	end

	assign accept   = in_valid & in_ready;
	assign in_ready = cnt_q <= pcms_pkg::QCNT_W'(pcms_pkg::QDEPTH - 2);

	assign bar_val = read_data & pcms_pkg::BAR_ADDR_MASK;
	assign win_top = {1'b0, window_base_q} + {1'b0, window_size_q};
	assign bar_ok  = !read_data[0] && (bar_val != '0) && (bar_val >= window_base_q)
		&& ({1'b0, bar_val} < win_top);
	assign fn_inc  = {1'b0, fn_q} + 4'd1;
	assign dev_inc = {1'b0, dev_q} + 6'd1;

	always_comb begin
		phase_n   = phase_q;
		dev_n     = dev_q;
		fn_n      = fn_q;
		bar_n     = bar_q;
		push_n    = 2'd0;
		res0      = '0;
		res1      = '0;
		adv       = 1'b0;
		whole_dev = 1'b0;
		rd_req    = 1'b0;
		rd_off    = pcms_pkg::OFF_ID;
		if (op == pcms_pkg::OP_START) begin
			dev_n   = '0;
			fn_n    = '0;
			bar_n   = '0;
			phase_n = pcms_pkg::PH_ID;
			rd_req  = 1'b1;
		end else begin
			case (phase_q)
				pcms_pkg::PH_ID: begin
					if (read_data[15:0] == pcms_pkg::VENDOR_ABSENT) begin
						adv       = 1'b1;
						whole_dev = (fn_q == '0);
					end else begin
						rd_req  = 1'b1;
						rd_off  = pcms_pkg::OFF_CLASS;
						phase_n = pcms_pkg::PH_CLASS;
					end
				end
				pcms_pkg::PH_CLASS: begin
					if (read_data[31:8] != match_class_q) begin
						adv = 1'b1;
					end else begin
						rd_req  = 1'b1;
						rd_off  = pcms_pkg::OFF_BAR0;
						phase_n = pcms_pkg::PH_BAR;
					end
				end
				pcms_pkg::PH_BAR: begin
					if (!bar_ok) begin
						adv = 1'b1;
					end else begin
						bar_n   = bar_val;
						rd_req  = 1'b1;
						rd_off  = pcms_pkg::OFF_CMD;
						phase_n = pcms_pkg::PH_CMD;
					end
				end
				pcms_pkg::PH_CMD: begin
					res0 = pcms_pkg::mk_result(pcms_pkg::KIND_WRITE, dev_q, fn_q, pcms_pkg::OFF_CMD,
						read_data | pcms_pkg::CMD_SET_BITS, '0, 1'b0);
					res1 = pcms_pkg::mk_result(pcms_pkg::KIND_FOUND, dev_q, fn_q, 8'h00,
						'0, bar_q, 1'b1);
					push_n  = 2'd2;
					phase_n = pcms_pkg::PH_DONE;
				end
				default: ;
			endcase
		end
		// step to the next candidate function
		if (adv) begin
			if (whole_dev || fn_inc >= pcms_pkg::FUNCTIONS_PER_DEVICE) begin
				fn_n = '0;
				if (dev_inc >= pcms_pkg::DEVICES_PER_BUS) begin
					dev_n   = '0;
					phase_n = pcms_pkg::PH_DONE;
					res0    = pcms_pkg::mk_result(pcms_pkg::KIND_NOT_FOUND, '0, '0, '0,
						'0, '0, 1'b1);
					push_n  = 2'd1;
				end else begin
					dev_n   = dev_inc[4:0];
					phase_n = pcms_pkg::PH_ID;
					rd_req  = 1'b1;
				end
			end else begin
				fn_n    = fn_inc[2:0];
				phase_n = pcms_pkg::PH_ID;
				rd_req  = 1'b1;
			end
		end
		if (rd_req) begin
			res0   = pcms_pkg::mk_result(pcms_pkg::KIND_READ, dev_n, fn_n, rd_off, '0, '0, 1'b1);
			push_n = 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= pcms_pkg::PH_IDLE;
			dev_q   <= '0;
			fn_q    <= '0;
			bar_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_n;
			dev_q   <= dev_n;
			fn_q    <= fn_n;
			bar_q   <= bar_n;
		end
	end

	// Result queue: up to two writes, one read per cycle
	assign pop = out_valid & out_ready;

	always_ff @(posedge clk) begin
		if (accept && push_n != 2'd0) begin
			q_mem[wr_ptr_q] <= res0;
		end
		if (accept && push_n == 2'd2) begin
			q_mem[wr_ptr_q + pcms_pkg::QPTR_W'(1)] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + pcms_pkg::QPTR_W'(push_n);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + pcms_pkg::QPTR_W'(1);
			end
			cnt_q <= cnt_q + (accept ? pcms_pkg::QCNT_W'(push_n) : '0)
				- pcms_pkg::QCNT_W'(pop);
		end
	end

	assign head            = q_mem[rd_ptr_q];
	assign out_valid       = cnt_q != '0;
	assign kind            = head.kind;
	assign device_number   = head.dev;
	assign function_number = head.fn;
	assign reg_offset      = head.off;
	assign ecam_offset     = {head.dev, head.fn, 4'h0, head.off};
	assign write_data      = head.wdata;
	assign bar_address     = head.bar;
	assign last            = head.last;

	`PCMS_ASSERT(a_queue_bound, clk, arst_n, cnt_q <= pcms_pkg::QCNT_W'(pcms_pkg::QDEPTH), "result queue overflow")
	`PCMS_ASSERT_NEXT(a_start_phase, clk, arst_n, accept && op == pcms_pkg::OP_START, phase_q == pcms_pkg::PH_ID, "start did not enter ID phase")
	`PCMS_ASSERT(a_write_not_last, clk, arst_n, !(out_valid && kind == pcms_pkg::KIND_WRITE) || !last, "command write flagged as last")
	`PCMS_ASSERT(a_found_bar, clk, arst_n, !(out_valid && kind == pcms_pkg::KIND_FOUND) || bar_address != '0, "found item with zero BAR")

endmodule

// File: sim/testbench.sv
// Self-checking testbench for pci_class_match_scanner: drives starts and config read responses,
// predicts every read, write, found and not-found item and checks them field by field.
// Depends on pcms_pkg and the scanner RTL only.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_PRINTED   = 40;

	typedef struct packed {
		logic [1:0]  kind;
		logic [4:0]  dev;
		logic [2:0]  fn;
		logic [7:0]  off;
		logic [19:0] ecam;
		logic [31:0] wdata;
		logic [31:0] bar;
		logic        last;
	} scan_result_t;

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        psel, penable, pwrite;
	logic [pcms_pkg::APB_AW-1:0] paddr;
	logic [31:0]                 pwdata, prdata;
	logic                        pready;
	logic                        in_valid, in_ready, op;
	logic [31:0]                 read_data;
	logic                        out_valid, out_ready;
	logic [1:0]                  kind;
	logic [4:0]                  device_number;
	logic [2:0]                  function_number;
	logic [7:0]                  reg_offset;
	logic [19:0]                 ecam_offset;
	logic [31:0]                 write_data, bar_address;
	logic                        last;

	// predictor state and its copy of the registers
	pcms_pkg::phase_t walk_phase;
	logic [4:0]       cur_dev;
	logic [2:0]       cur_fn;
	logic [31:0]      hit_bar;
	logic [23:0]      want_class;
	logic [31:0]      win_lo, win_len;

	scan_result_t pending[$];

	int error_count     = 0;
	int items_sent      = 0;
	int results_checked = 0;
	int found_seen      = 0;
	int not_found_seen  = 0;
	int cycle_count     = 0;
	int send_gap_max    = 3;
	int recv_gap_max    = 3;
	int absent_pct      = 30;
	int ready_delay     = 0;
	int hold_request    = 0;
	int stall_left      = 0;

	pci_class_match_scanner dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.op              (op),
		.read_data       (read_data),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.kind            (kind),
		.device_number   (device_number),
		.function_number (function_number),
		.reg_offset      (reg_offset),
		.ecam_offset     (ecam_offset),
		.write_data      (write_data),
		.bar_address     (bar_address),
		.last            (last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	task automatic report(input string msg);
		error_count++;
		if (error_count <= MAX_PRINTED)
			$display("MISMATCH at %0t ns: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
		if (got !== want)
			report($sformatf("%s got %h want %h", name, got, want));
	endtask

	// ---------------- predictor ----------------

	task automatic expect_result(input logic [1:0] k, input logic [4:0] dev, input logic [2:0] fn,
			input logic [7:0] off, input logic [31:0] wd, input logic [31:0] bar, input logic lst);
		scan_result_t r;
		r.kind  = k;
		r.dev   = dev;
		r.fn    = fn;
		r.off   = off;
		r.ecam  = {dev, fn, 4'h0, off};
		r.wdata = wd;
		r.bar   = bar;
		r.last  = lst;
		pending.push_back(r);
	endtask

	task automatic request_read(input logic [7:0] off, input pcms_pkg::phase_t next);
		walk_phase = next;
		expect_result(pcms_pkg::KIND_READ, cur_dev, cur_fn, off, 32'h0, 32'h0, 1'b1);
	endtask

	// step to the next function, or to the next device when the whole device is skipped
	task automatic next_candidate(input logic whole_device);
		if (whole_device || {1'b0, cur_fn} == pcms_pkg::FUNCTIONS_PER_DEVICE - 4'd1) begin
			cur_fn = '0;
			if ({1'b0, cur_dev} == pcms_pkg::DEVICES_PER_BUS - 6'd1) begin
				cur_dev    = '0;
				walk_phase = pcms_pkg::PH_DONE;
				expect_result(pcms_pkg::KIND_NOT_FOUND, '0, '0, '0, '0, '0, 1'b1);
			end else begin
				cur_dev++;
				request_read(pcms_pkg::OFF_ID, pcms_pkg::PH_ID);
			end
		end else begin
			cur_fn++;
			request_read(pcms_pkg::OFF_ID, pcms_pkg::PH_ID);
		end
	endtask

	task automatic predict_scan(input logic o, input logic [31:0] d);
		logic [31:0] bar_addr;
		logic [32:0] top;
		bar_addr = d & pcms_pkg::BAR_ADDR_MASK;
		top      = {1'b0, win_lo} + {1'b0, win_len};
		if (o == pcms_pkg::OP_START) begin
			cur_dev = '0;
			cur_fn  = '0;
			hit_bar = '0;
			request_read(pcms_pkg::OFF_ID, pcms_pkg::PH_ID);
		end else begin
			case (walk_phase)
				pcms_pkg::PH_ID: begin
					if (d[15:0] == pcms_pkg::VENDOR_ABSENT)
						next_candidate(cur_fn == 3'd0);
					else
						request_read(pcms_pkg::OFF_CLASS, pcms_pkg::PH_CLASS);
				end
				pcms_pkg::PH_CLASS: begin
					if (d[31:8] != want_class)
						next_candidate(1'b0);
					else
						request_read(pcms_pkg::OFF_BAR0, pcms_pkg::PH_BAR);
				end
				pcms_pkg::PH_BAR: begin
					if (d[0] || bar_addr == 32'h0 || bar_addr < win_lo
						|| {1'b0, bar_addr} >= top)
						next_candidate(1'b0);
					else begin
						hit_bar = bar_addr;
						request_read(pcms_pkg::OFF_CMD, pcms_pkg::PH_CMD);
					end
				end
				pcms_pkg::PH_CMD: begin
					expect_result(pcms_pkg::KIND_WRITE, cur_dev, cur_fn, pcms_pkg::OFF_CMD,
						d | pcms_pkg::CMD_SET_BITS, 32'h0, 1'b0);
					expect_result(pcms_pkg::KIND_FOUND, cur_dev, cur_fn, 8'h00, 32'h0,
						hit_bar, 1'b1);
					walk_phase = pcms_pkg::PH_DONE;
				end
				default: ;
			endcase
		end
	endtask

	// ---------------- drivers ----------------

	task automatic send_item(input logic o, input logic [31:0] d);
		int gap;
		gap = $urandom_range(0, send_gap_max);
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		op        <= o;
		read_data <= d;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_scan(o, d);
		items_sent++;
	endtask

	// drop valid and wait until every expected item has come out
	task automatic settle_scanner();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic read_check(input logic [1:0] idx);
		logic [31:0] want;
		want = (idx == pcms_pkg::REG_MATCH_CLASS) ? {8'h00, want_class} :
			(idx == pcms_pkg::REG_WINDOW_BASE) ? win_lo : win_len;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== want)
			report($sformatf("register %0d reads %h want %h", idx, prdata, want));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			pcms_pkg::REG_MATCH_CLASS: want_class = val[23:0];
			pcms_pkg::REG_WINDOW_BASE: win_lo     = val;
			default:                   win_len    = val;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		read_check(idx);
	endtask

	task automatic set_config(input logic [23:0] cls, input logic [31:0] base,
			input logic [31:0] size);
		write_reg(pcms_pkg::REG_MATCH_CLASS, {8'h00, cls});
		write_reg(pcms_pkg::REG_WINDOW_BASE, base);
		write_reg(pcms_pkg::REG_WINDOW_SIZE, size);
	endtask

	// answer the outstanding read with a plausible dword
	function automatic logic [31:0] craft_response();
		int          pick;
		logic [31:0] r, step_in;
		logic [32:0] spot;
		r    = $urandom;
		pick = $urandom_range(0, 99);
		case (walk_phase)
			pcms_pkg::PH_ID: begin
				if (pick < ((cur_fn == 3'd0) ? absent_pct : 50))
					r[15:0] = pcms_pkg::VENDOR_ABSENT;
				else if (r[15:0] == pcms_pkg::VENDOR_ABSENT)
					r[0] = 1'b0;
			end
			pcms_pkg::PH_CLASS: begin
				if (pick < 50)
					r[31:8] = want_class;
				else if (pick < 75)
					r[31:8] = want_class ^ (24'd1 << $urandom_range(0, 23));
			end
			pcms_pkg::PH_BAR: begin
				step_in = (win_len == 32'h0) ? 32'h0 : $urandom % win_len;
				case ($urandom_range(0, 5))
					0, 1, 2: begin
						spot = {1'b0, win_lo} + {1'b0, step_in};
						if (spot[32])
							spot = {1'b0, win_lo};
						r = {spot[31:4], r[3:1], 1'b0};
					end
					3: r[0] = 1'b1;                  // I/O BAR
					4: r = {28'h0, r[3:1], 1'b0};    // memory BAR with zero address
					default: begin                   // right at the window top
						spot = {1'b0, win_lo} + {1'b0, win_len};
						r = {spot[31:4], r[3:1], 1'b0};
					end
				endcase
			end
			default: ;
		endcase
		return r;
	endfunction

	// mostly well-formed scans, some restarts and garbage responses
	task automatic random_scans(input int count);
		int          counted, roll;
		logic        busy, o;
		logic [31:0] d;
		counted = 0;
		while (counted < count) begin
			busy = (walk_phase != pcms_pkg::PH_IDLE && walk_phase != pcms_pkg::PH_DONE);
			roll = $urandom_range(0, 99);
			d    = $urandom;
			if (!busy)
				o = (roll < 85) ? pcms_pkg::OP_START : pcms_pkg::OP_RESPONSE;
			else if (roll < 4)
				o = pcms_pkg::OP_START;
			else begin
				o = pcms_pkg::OP_RESPONSE;
				if (roll >= 12)
					d = craft_response();
			end
			if (busy || o == pcms_pkg::OP_START)
				counted++;
			send_item(o, d);
		end
		settle_scanner();
	endtask

	// ---------------- result side ----------------

	always @(negedge clk) begin
		if (hold_request != 0) begin
			stall_left   = hold_request;
			hold_request = 0;
		end
		if (stall_left != 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (ready_delay != 0) begin
			ready_delay--;
			out_ready <= 1'b0;
		end else
			out_ready <= 1'b1;
	end

	always @(posedge clk) begin : check_results
		scan_result_t want;
		if (arst_n && out_valid && out_ready) begin
			ready_delay = $urandom_range(0, recv_gap_max);
			if (pending.size() == 0)
				report($sformatf("unexpected item of kind %0d", kind));
			else begin
				want = pending.pop_front();
				check_field("kind", 32'(kind), 32'(want.kind));
				check_field("device_number", 32'(device_number), 32'(want.dev));
				check_field("function_number", 32'(function_number), 32'(want.fn));
				check_field("reg_offset", 32'(reg_offset), 32'(want.off));
				check_field("ecam_offset", 32'(ecam_offset), 32'(want.ecam));
				check_field("write_data", write_data, want.wdata);
				check_field("bar_address", bar_address, want.bar);
				check_field("last", 32'(last), 32'(want.last));
				results_checked++;
				if (want.kind == pcms_pkg::KIND_FOUND)
					found_seen++;
				if (want.kind == pcms_pkg::KIND_NOT_FOUND)
					not_found_seen++;
			end
		end
	end

	// ---------------- tests ----------------

	task automatic test_reset_values();
		read_check(pcms_pkg::REG_MATCH_CLASS);
		read_check(pcms_pkg::REG_WINDOW_BASE);
		read_check(pcms_pkg::REG_WINDOW_SIZE);
		send_item(pcms_pkg::OP_RESPONSE, 32'h1234_5678);     // idle: ignored
		send_item(pcms_pkg::OP_START, 32'hFFFF_FFFF);
		send_item(pcms_pkg::OP_RESPONSE, 32'h0000_0000);     // vendor 0 counts as present
		send_item(pcms_pkg::OP_RESPONSE, {want_class, 8'h00});
		send_item(pcms_pkg::OP_RESPONSE, 32'h8000_0000);     // empty window rejects every BAR
		settle_scanner();
	endtask

	task automatic test_scan_cases();
		logic [31:0] bars [5];
		bars = '{32'h8000_0001, 32'h0000_0008, 32'h7FFF_FFF0, 32'h9000_0000, 32'h8FFF_FFFC};
		set_config(24'h010802, 32'h8000_0000, 32'h1000_0000);
		send_item(pcms_pkg::OP_START, 32'h0);
		send_item(pcms_pkg::OP_RESPONSE, 32'hFFFF_FFFF);     // absent at function 0: skip device
		send_item(pcms_pkg::OP_RESPONSE, 32'h1234_8086);
		send_item(pcms_pkg::OP_RESPONSE, 32'h0C03_3000);     // class miss
		send_item(pcms_pkg::OP_RESPONSE, 32'hABCD_FFFF);     // absent at function 1
		// I/O, zero, below window, at window top, then the last aligned address inside
		foreach (bars[i]) begin
			send_item(pcms_pkg::OP_RESPONSE, 32'h0000_1AF4);
			send_item(pcms_pkg::OP_RESPONSE, {want_class, 8'h01});
			send_item(pcms_pkg::OP_RESPONSE, bars[i]);
		end
		send_item(pcms_pkg::OP_RESPONSE, 32'h0010_0000);     // command dword: write plus found
		send_item(pcms_pkg::OP_RESPONSE, 32'h5555_AAAA);     // done: ignored
		settle_scanner();
	endtask

	task automatic test_restart_extremes();
		set_config(24'hFFFFFF, 32'hFFFF_0000, 32'hFFFF_FFFF);
		send_item(pcms_pkg::OP_START, 32'h0);
		send_item(pcms_pkg::OP_RESPONSE, 32'h0000_0001);
		send_item(pcms_pkg::OP_RESPONSE, 32'hFFFF_FFFF);
		send_item(pcms_pkg::OP_START, 32'hFFFF_FFFF);        // abandon and restart mid-scan
		send_item(pcms_pkg::OP_RESPONSE, 32'h0000_0001);
		send_item(pcms_pkg::OP_RESPONSE, 32'hFFFF_FFFF);
		send_item(pcms_pkg::OP_RESPONSE, 32'hFFFF_FFFC);     // window top past 32 bits
		send_item(pcms_pkg::OP_RESPONSE, 32'hFFFF_FFFF);
		settle_scanner();
	endtask

	task automatic test_random_traffic();
		set_config(24'($urandom_range(0, 24'hFFFFFF)), 32'h0, 32'hFFFF_FFFF);
		random_scans(150);
		send_gap_max = 0;
		recv_gap_max = 0;
		set_config(24'h000000, $urandom, $urandom >> $urandom_range(0, 31));
		random_scans(150);
		send_gap_max = 3;
		recv_gap_max = 3;
		// sparse bus and an empty window: scans run off the end
		absent_pct = 85;
		set_config(24'($urandom_range(0, 24'hFFFFFF)), $urandom, 32'h0);
		random_scans(150);
		absent_pct = 30;
		set_config(24'($urandom_range(0, 24'hFFFFFF)), 32'hFFFF_FFF0, 32'hFFFF_FFFF);
		random_scans(150);
	endtask

	task automatic test_backpressure();
		int n;
		set_config(24'($urandom_range(0, 24'hFFFFFF)), 32'h0, 32'hFFFF_FFFF);
		send_gap_max = 0;
		hold_request = 60;
		send_item(pcms_pkg::OP_START, $urandom);
		for (n = 0; n < 20; n++)
			send_item(pcms_pkg::OP_RESPONSE, craft_response());
		settle_scanner();
		send_gap_max = 3;
	endtask

	initial begin
		arst_n     = 1'b0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		in_valid   = 1'b0;
		op         = pcms_pkg::OP_START;
		read_data  = '0;
		out_ready  = 1'b0;
		walk_phase = pcms_pkg::PH_IDLE;
		cur_dev    = '0;
		cur_fn     = '0;
		hit_bar    = '0;
		want_class = pcms_pkg::MATCH_CLASS_RESET;
		win_lo     = '0;
		win_len    = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_values();
		test_scan_cases();
		test_restart_extremes();
		test_random_traffic();
		test_backpressure();

		$display("run summary: %0d items sent, %0d results checked, %0d found, %0d not found",
			items_sent, results_checked, found_seen, not_found_seen);
		$display("run summary: %0d mismatches, %0d items still expected",
			error_count, pending.size());
		if (error_count == 0 && pending.size() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
